// ----- rtl/container_discipline_checker_top_defines.svh -----
// ----------------------------------------------------------------------------
// container_discipline_checker_top_defines.svh
// Assertion macros shared by the container discipline checker RTL.
// ----------------------------------------------------------------------------
`ifndef CONTAINER_DISCIPLINE_CHECKER_TOP_DEFINES_SVH
`define CONTAINER_DISCIPLINE_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdc assertion failed");

// Next-cycle implication, checked outside reset.
`define CDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdc assertion failed");

`endif

// ----- rtl/cdc_pkg.sv -----
// ----------------------------------------------------------------------------
// cdc_pkg
// Types, constants and the verdict encoder of the container discipline checker.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_VALUE_W     = 32;
  localparam int VERDICT_W      = 3;

  localparam logic [VERDICT_W-1:0] V_IMPOSSIBLE = 3'd0;
  localparam logic [VERDICT_W-1:0] V_NOT_SURE   = 3'd1;
  localparam logic [VERDICT_W-1:0] V_QUEUE      = 3'd2;
  localparam logic [VERDICT_W-1:0] V_PRIO_QUEUE = 3'd3;
  localparam logic [VERDICT_W-1:0] V_STACK      = 3'd4;

  // per-cycle command to every cell of the sorted chain
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic logic [VERDICT_W-1:0] verdict_f(input logic f, input logic h,
                                                     input logic l);
    logic [1:0] n;
    n = {1'b0, f} + {1'b0, h} + {1'b0, l};
    if (n == 2'd0)      verdict_f = V_IMPOSSIBLE;
    else if (n != 2'd1) verdict_f = V_NOT_SURE;
    else if (f)         verdict_f = V_QUEUE;
    else if (h)         verdict_f = V_PRIO_QUEUE;
    else                verdict_f = V_STACK;
  endfunction

endpackage

// ----- rtl/cdc_in_if.sv -----
// ----------------------------------------------------------------------------
// cdc_in_if
// Event channel: push/pop events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdc_in_if import cdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  first_of_case;
  logic                  is_pop;
  logic [IN_VALUE_W-1:0] value;

  modport source (output valid, first_of_case, is_pop, value, input ready);
  modport sink   (input valid, first_of_case, is_pop, value, output ready);
endinterface

interface cdc_out_if import cdc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 may_be_fifo;
  logic                 may_be_heap;
  logic                 may_be_lifo;
  logic                 overflowed;

  modport source (output valid, verdict, may_be_fifo, may_be_heap, may_be_lifo, overflowed,
                  input ready);
  modport sink   (input valid, verdict, may_be_fifo, may_be_heap, may_be_lifo, overflowed,
                  output ready);
endinterface

// ----- rtl/cdc_cell.sv -----
// ----------------------------------------------------------------------------
// cdc_cell
// One slot of the descending sorted chain that models the max-priority queue.
// ----------------------------------------------------------------------------
module cdc_cell import cdc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] v,
  input  logic                  prev_ge,
  input  logic [VALUE_BITS-1:0] prev_val,
  input  logic                  prev_occ,
  input  logic [VALUE_BITS-1:0] next_val,
  input  logic                  next_occ,
  output logic [VALUE_BITS-1:0] val_o,
  output logic                  occ_o,
  output logic                  ge_o
);

  logic [VALUE_BITS-1:0] val_r;
  logic                  occ_r;

  assign val_o = val_r;
  assign occ_o = occ_r;
  assign ge_o  = occ_r && (val_r >= v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctl.clear) begin
      occ_r <= 1'b0;
    end else if (ctl.push) begin
      occ_r <= occ_r | prev_occ;
    end else if (ctl.pop) begin
      occ_r <= next_occ;
    end
  end

  // push: keep if not smaller, take v at the insertion point, else shift down
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (!ge_o) begin
        val_r <= prev_ge ? v : prev_val;
      end
    end else if (ctl.pop) begin
      val_r <= next_val;
    end
  end

endmodule

// ----- rtl/container_discipline_checker_top.sv -----
// ----------------------------------------------------------------------------
// container_discipline_checker_top
// Checks a push/pop trace against queue, stack and max-priority queue.
// ----------------------------------------------------------------------------
// Each transaction steps through accept, a registered read of the queue head
// and stack top memories, then evaluate and update (held while the output
// register is full). The priority queue is a chain of DEPTH sorted cells that
// shifts one place per push or pop, so its maximum sits in cell zero. The
// result waits in an output register; the next event is accepted once the
// previous result has been loaded. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "container_discipline_checker_top_defines.svh"

module container_discipline_checker_top import cdc_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  cdc_in_if.sink   in_ch,
  cdc_out_if.source out_ch
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int VB_I = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic                  pop_r;
  logic [VALUE_BITS-1:0] v_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  fok_r, fok_nxt, hok_r, hok_nxt, lok_r, lok_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_v_r;
  logic [VERDICT_W-1:0]  verdict_r;
  logic                  o_f_r, o_h_r, o_l_r, o_ovf_r;

  logic [VALUE_BITS-1:0] fifo_mem [DEPTH];
  logic [VALUE_BITS-1:0] lifo_mem [DEPTH];
  logic [VALUE_BITS-1:0] frd_r, lrd_r;

  logic                  acc, commit, first_acc;
  logic                  do_push, do_pop;
  logic [AW:0]           tail_sum;
  logic [AW-1:0]         tail, top_idx;
  cell_ctl_t             ctl;

  logic [VALUE_BITS-1:0] cval [DEPTH];
  logic                  cocc [DEPTH];
  logic                  cge  [DEPTH];

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc       = in_ch.valid && in_ch.ready;
  assign first_acc = acc && in_ch.first_of_case;
  assign commit    = (state_r == S_EX) && (!out_v_r || out_ch.ready);

  assign tail_sum = (AW+1)'(head_r) + (AW+1)'(cnt_r);
  assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : AW'(tail_sum);
  assign top_idx  = AW'(cnt_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    fok_nxt   = fok_r;
    hok_nxt   = hok_r;
    lok_nxt   = lok_r;
    ovf_nxt   = ovf_r;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_RD;
          if (in_ch.first_of_case) begin
            head_nxt = '0;
            cnt_nxt  = '0;
            fok_nxt  = 1'b1;
            hok_nxt  = 1'b1;
            lok_nxt  = 1'b1;
            ovf_nxt  = 1'b0;
          end
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        if (commit) begin
          state_nxt = S_IDLE;
          if (fok_r || hok_r || lok_r) begin
            if (!pop_r) begin
              if (cnt_r == CW'(DEPTH)) begin
                ovf_nxt = 1'b1;
                fok_nxt = 1'b0;
                hok_nxt = 1'b0;
                lok_nxt = 1'b0;
              end else begin
                do_push = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end else begin
              if (cnt_r == '0) begin
                fok_nxt = 1'b0;
                hok_nxt = 1'b0;
                lok_nxt = 1'b0;
              end else begin
                do_pop   = 1'b1;
                fok_nxt  = fok_r && (frd_r == v_r);
                hok_nxt  = hok_r && (cval[0] == v_r);
                lok_nxt  = lok_r && (lrd_r == v_r);
                head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
                cnt_nxt  = cnt_r - CW'(1);
              end
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      fok_r   <= 1'b1;
      hok_r   <= 1'b1;
      lok_r   <= 1'b1;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      fok_r   <= fok_nxt;
      hok_r   <= hok_nxt;
      lok_r   <= lok_nxt;
      ovf_r   <= ovf_nxt;
      if (commit)            out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pop_r <= in_ch.is_pop;
      v_r   <= VALUE_BITS'(in_ch.value[VB_I-1:0]);
    end
    if (commit) begin
      verdict_r <= verdict_f(fok_nxt, hok_nxt, lok_nxt);
      o_f_r     <= fok_nxt;
      o_h_r     <= hok_nxt;
      o_l_r     <= lok_nxt;
      o_ovf_r   <= ovf_nxt;
    end
  end

  // queue and stack memories; reads registered, addresses stable from accept
  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_mem[tail]              <= v_r;
      lifo_mem[cnt_r[AW-1:0]]     <= v_r;
    end
    frd_r <= fifo_mem[head_r];
    lrd_r <= lifo_mem[top_idx];
  end

  assign ctl.clear = first_acc;
  assign ctl.push  = do_push;
  assign ctl.pop   = do_pop;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  p_ge, p_occ, n_occ;
    logic [VALUE_BITS-1:0] p_val, n_val;
    if (i == 0) begin : g_first
      assign p_ge  = 1'b1;
      assign p_occ = 1'b1;
      assign p_val = v_r;
    end else begin : g_mid
      assign p_ge  = cge[i-1];
      assign p_occ = cocc[i-1];
      assign p_val = cval[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign n_occ = 1'b0;
      assign n_val = v_r;
    end else begin : g_nxt
      assign n_occ = cocc[i+1];
      assign n_val = cval[i+1];
    end
    cdc_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .v        (v_r),
      .prev_ge  (p_ge),
      .prev_val (p_val),
      .prev_occ (p_occ),
      .next_val (n_val),
      .next_occ (n_occ),
      .val_o    (cval[i]),
      .occ_o    (cocc[i]),
      .ge_o     (cge[i])
    );
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.verdict     = verdict_r;
  assign out_ch.may_be_fifo = o_f_r;
  assign out_ch.may_be_heap = o_h_r;
  assign out_ch.may_be_lifo = o_l_r;
  assign out_ch.overflowed  = o_ovf_r;

  `CDC_ASSERT_SAME(a_cnt_range, 1'b1, cnt_r <= CW'(DEPTH))
  `CDC_ASSERT_SAME(a_heap_occ, 1'b1, cocc[0] == (cnt_r != '0))
  `CDC_ASSERT_SAME(a_ovf_flags, ovf_r, !(fok_r || hok_r || lok_r))
  `CDC_ASSERT_NEXT(a_acc_rd, acc, state_r == S_RD)

endmodule

// ----- tb/cdc_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_tb_pkg
// Shared types of the container discipline checker testbench.
// ----------------------------------------------------------------------------
package cdc_tb_pkg;
  import cdc_pkg::*;

  typedef struct packed {
    logic                  first_of_case;
    logic                  is_pop;
    logic [IN_VALUE_W-1:0] value;
  } event_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic                 may_be_fifo;
    logic                 may_be_heap;
    logic                 may_be_lifo;
    logic                 overflowed;
  } verdict_rec_t;

  // directed row: event plus optional typed-in expectation
  typedef struct packed {
    event_t       ev;
    logic         has_exp;
    verdict_rec_t exp;
  } stim_row_t;
endpackage

// ----- tb/container_discipline_checker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// container_discipline_checker_top_tb
// Drives push/pop traces into the checker and compares every verdict with
// a behavioral model of the FIFO, stack and max-heap disciplines.
// ----------------------------------------------------------------------------
module container_discipline_checker_top_tb;
  import cdc_pkg::*;
  import cdc_tb_pkg::*;

  localparam int DEPTH    = DEPTH_DEF;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cdc_in_if  in_ch ();
  cdc_out_if out_ch ();

  container_discipline_checker_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic [31:0] q_mem [DEPTH];
  int          q_head, q_cnt;
  logic [31:0] stk_mem [DEPTH];
  int          stk_cnt;
  logic [31:0] pq_mem [$];
  logic        fifo_ok, heap_ok, lifo_ok, ovf_seen;

  verdict_rec_t verdict_q [$];
  verdict_rec_t typed_q [$];
  logic         typed_has_q [$];
  int           errors = 0;
  int           wd = 0;

  function automatic void start_case_m();
    q_head = 0; q_cnt = 0; stk_cnt = 0; pq_mem.delete();
    fifo_ok = 1; heap_ok = 1; lifo_ok = 1; ovf_seen = 0;
  endfunction

  function automatic verdict_rec_t discipline_predict(event_t ev);
    verdict_rec_t r;
    int mi;
    if (ev.first_of_case) start_case_m();
    if (fifo_ok || heap_ok || lifo_ok) begin
      if (!ev.is_pop) begin
        if (q_cnt >= DEPTH) begin
          ovf_seen = 1; fifo_ok = 0; heap_ok = 0; lifo_ok = 0;
        end else begin
          q_mem[(q_head + q_cnt) % DEPTH] = ev.value; q_cnt++;
          stk_mem[stk_cnt] = ev.value; stk_cnt++;
          pq_mem.insert(pq_mem.size(), ev.value);
        end
      end else if (q_cnt == 0) begin
        fifo_ok = 0; heap_ok = 0; lifo_ok = 0;
      end else begin
        fifo_ok = fifo_ok && (q_mem[q_head] == ev.value);
        q_head = (q_head + 1) % DEPTH; q_cnt--;
        mi = 0;
        foreach (pq_mem[i]) if (pq_mem[i] > pq_mem[mi]) mi = i;
        heap_ok = heap_ok && (pq_mem[mi] == ev.value);
        pq_mem.delete(mi);
        lifo_ok = lifo_ok && (stk_mem[stk_cnt-1] == ev.value);
        stk_cnt--;
      end
    end
    r.may_be_fifo = fifo_ok; r.may_be_heap = heap_ok; r.may_be_lifo = lifo_ok;
    r.overflowed = ovf_seen;
    case ({fifo_ok, heap_ok, lifo_ok})
      3'b000:  r.verdict = V_IMPOSSIBLE;
      3'b100:  r.verdict = V_QUEUE;
      3'b010:  r.verdict = V_PRIO_QUEUE;
      3'b001:  r.verdict = V_STACK;
      default: r.verdict = V_NOT_SURE;
    endcase
    return r;
  endfunction

  function automatic verdict_rec_t vr(logic [2:0] v, logic f, logic h, logic l, logic o);
    verdict_rec_t r;
    r.verdict = v; r.may_be_fifo = f; r.may_be_heap = h; r.may_be_lifo = l;
    r.overflowed = o;
    return r;
  endfunction

  function automatic event_t mk(logic f, logic p, logic [31:0] v);
    event_t e;
    e.first_of_case = f; e.is_pop = p; e.value = v;
    return e;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays up after a transaction; it drops only for a gap or a drain
  task automatic send(event_t ev, logic has_exp, verdict_rec_t exp);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_of_case <= ev.first_of_case;
    in_ch.is_pop <= ev.is_pop;
    in_ch.value <= ev.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    verdict_q.insert(verdict_q.size(), discipline_predict(ev));
    typed_q.insert(typed_q.size(), exp);
    typed_has_q.insert(typed_has_q.size(), has_exp);
    @(negedge clk);
  endtask

  // sink with random stalls
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_rec_t act, exp, typed;
    logic         th;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wd <= 0;
      else wd <= wd + 1;
      if (out_ch.valid && out_ch.ready) begin
        act = vr(out_ch.verdict, out_ch.may_be_fifo, out_ch.may_be_heap,
                 out_ch.may_be_lifo, out_ch.overflowed);
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, act);
          errors++;
        end else begin
          exp = verdict_q.pop_front();
          typed = typed_q.pop_front();
          th = typed_has_q.pop_front();
          if (th && typed != exp) begin
            $display("%0t: table row exp %p model %p", $time, typed, exp);
            errors++;
          end
          if (act.verdict !== exp.verdict) begin
            $display("%0t: verdict exp %0d act %0d", $time, exp.verdict, act.verdict);
            errors++;
          end
          if (act.may_be_fifo !== exp.may_be_fifo) begin
            $display("%0t: may_be_fifo exp %0b act %0b", $time, exp.may_be_fifo,
                     act.may_be_fifo);
            errors++;
          end
          if (act.may_be_heap !== exp.may_be_heap) begin
            $display("%0t: may_be_heap exp %0b act %0b", $time, exp.may_be_heap,
                     act.may_be_heap);
            errors++;
          end
          if (act.may_be_lifo !== exp.may_be_lifo) begin
            $display("%0t: may_be_lifo exp %0b act %0b", $time, exp.may_be_lifo,
                     act.may_be_lifo);
            errors++;
          end
          if (act.overflowed !== exp.overflowed) begin
            $display("%0t: overflowed exp %0b act %0b", $time, exp.overflowed,
                     act.overflowed);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (wd >= WD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  stim_row_t table_rows [$];

  task automatic add_row(event_t e, logic h, verdict_rec_t x);
    stim_row_t r;
    r.ev = e; r.has_exp = h; r.exp = x;
    table_rows.insert(table_rows.size(), r);
  endtask

  // one random case: mostly a consistent trace of one discipline
  task automatic random_case(int n_ev);
    logic [31:0] shadow [$];
    logic [31:0] v;
    int          kind, mi;
    verdict_rec_t none;
    none = '0;
    kind = $urandom_range(0, 4);
    for (int i = 0; i < n_ev; i++) begin
      if ($urandom_range(0, 1) == 0 || shadow.size() == 0) begin
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 7);
          1: v = $urandom;
          2: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(0, 1);
          default: v = $urandom_range(0, 255);
        endcase
        if (kind == 4 && shadow.size() == 0 && $urandom_range(0, 9) == 0)
          send(mk(i == 0, 1'b1, v), 1'b0, none);
        else begin
          send(mk(i == 0, 1'b0, v), 1'b0, none);
          shadow.insert(shadow.size(), v);
        end
      end else begin
        case (kind)
          0: v = shadow.pop_front();
          1: v = shadow.pop_back();
          2: begin
            mi = 0;
            foreach (shadow[k]) if (shadow[k] > shadow[mi]) mi = k;
            v = shadow[mi]; shadow.delete(mi);
          end
          default: begin
            mi = $urandom_range(0, shadow.size() - 1);
            v = ($urandom_range(0, 3) == 0) ? $urandom : shadow[mi];
            shadow.delete(mi);
          end
        endcase
        send(mk(i == 0, 1'b1, v), 1'b0, none);
      end
    end
  endtask

  initial begin
    int sent;
    verdict_rec_t none;
    none = '0;
    in_ch.valid = 1'b0; in_ch.first_of_case = 1'b0; in_ch.is_pop = 1'b0;
    in_ch.value = '0;
    start_case_m();

    // after reset: pop from empty store
    add_row(mk(0, 1, 32'h0), 1, vr(V_IMPOSSIBLE, 0, 0, 0, 0));
    // impossible state ignores events
    add_row(mk(0, 0, 32'h5), 1, vr(V_IMPOSSIBLE, 0, 0, 0, 0));
    add_row(mk(1, 0, 32'hFFFF_FFFF), 1, vr(V_NOT_SURE, 1, 1, 1, 0));
    add_row(mk(0, 0, 32'h0), 1, vr(V_NOT_SURE, 1, 1, 1, 0));
    add_row(mk(0, 1, 32'hFFFF_FFFF), 1, vr(V_NOT_SURE, 1, 1, 0, 0));
    add_row(mk(0, 1, 32'h0), 1, vr(V_NOT_SURE, 1, 1, 0, 0));
    add_row(mk(0, 1, 32'h0), 1, vr(V_IMPOSSIBLE, 0, 0, 0, 0));
    // stack and priority queue both fit
    add_row(mk(1, 0, 32'h1), 0, none);
    add_row(mk(0, 0, 32'h2), 0, none);
    add_row(mk(0, 1, 32'h2), 1, vr(V_NOT_SURE, 0, 1, 1, 0));
    add_row(mk(0, 0, 32'h3), 0, none);
    add_row(mk(0, 1, 32'h3), 0, none);
    add_row(mk(0, 1, 32'h1), 0, none);
    // queue only
    add_row(mk(1, 0, 32'h1), 0, none);
    add_row(mk(0, 0, 32'h2), 0, none);
    add_row(mk(0, 1, 32'h1), 1, vr(V_QUEUE, 1, 0, 0, 0));
    // priority queue only
    add_row(mk(1, 0, 32'h2), 0, none);
    add_row(mk(0, 0, 32'h9), 0, none);
    add_row(mk(0, 0, 32'h1), 0, none);
    add_row(mk(0, 1, 32'h9), 0, none);
    add_row(mk(0, 1, 32'h2), 0, none);
    // wrong value matches nothing
    add_row(mk(1, 0, 32'hA5A5_5A5A), 0, none);
    add_row(mk(0, 1, 32'h5A5A_A5A5), 1, vr(V_IMPOSSIBLE, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) send(table_rows[i].ev, table_rows[i].has_exp, table_rows[i].exp);

    // overflow: fill the stores, then one more push and a pop
    send(mk(1, 0, $urandom), 1'b0, none);
    for (int i = 1; i < DEPTH; i++) send(mk(0, 0, $urandom_range(0, 1000)), 1'b0, none);
    send(mk(0, 0, 32'h7), 1'b1, vr(V_IMPOSSIBLE, 0, 0, 0, 1));
    send(mk(0, 1, 32'h7), 1'b1, vr(V_IMPOSSIBLE, 0, 0, 0, 1));
    send(mk(1, 0, 32'h7), 1'b1, vr(V_NOT_SURE, 1, 1, 1, 0));

    // hold off until the block drains
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);

    sent = 0;
    while (sent < 1650) begin
      int n;
      n = $urandom_range(2, 24);
      random_case(n);
      sent += n;
    end

    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- container_discipline_checker_top.f -----
+incdir+rtl
rtl/cdc_pkg.sv
rtl/cdc_in_if.sv
rtl/cdc_cell.sv
rtl/container_discipline_checker_top.sv
tb/cdc_tb_pkg.sv
tb/container_discipline_checker_top_tb.sv
